// ===== hw/rtl/cic_pkg.sv =====
// Shared types and constants for the curve index encoder and decoder.
package cic_pkg;

  localparam int unsigned MAX_ORDER_DEF  = 16;
  localparam int unsigned RULE_COUNT_DEF = 7;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned INDEX_W    = 32;
  localparam int unsigned ORDER_W    = 5;
  localparam int unsigned RULE_W     = 20;
  localparam int unsigned RULE_IDX_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_BASE = 3'd1;

  // Action codes.
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd8;
  localparam logic [RULE_W-1:0]  RULE_RESET  = 20'd228;

  // One item as it travels down the row of cells.
  typedef struct packed {
    logic                  valid;
    logic                  action;
    logic [COORD_W-1:0]    x_cell;
    logic [COORD_W-1:0]    y_cell;
    logic [INDEX_W-1:0]    curve_position;
    logic [RULE_IDX_W-1:0] rule;
    logic [INDEX_W-1:0]    index_acc;
    logic [COORD_W-1:0]    x_acc;
    logic [COORD_W-1:0]    y_acc;
  } lane_t;

endpackage

// ===== hw/rtl/cic_cell.sv =====
// One level of the curve walk: a registered cell that handles a single bit level.
module cic_cell #(
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned RULE_COUNT = cic_pkg::RULE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cic_pkg::ORDER_W-1:0]    order_i,
  input  logic [cic_pkg::RULE_W-1:0]     rules_i [RULE_COUNT],
  input  cic_pkg::lane_t                 lane_i,
  output cic_pkg::lane_t                 lane_o
);

  cic_pkg::lane_t              lane_r;
  cic_pkg::lane_t              lane_nxt;
  logic [cic_pkg::RULE_W-1:0]  word;
  logic                        active;
  logic [1:0]                  quad;
  logic [1:0]                  digit;
  logic [1:0]                  enc_pos;
  logic [2:0]                  next_raw;
  logic [cic_pkg::RULE_IDX_W-1:0] next_rule;

  assign active = (order_i > cic_pkg::ORDER_W'(LEVEL));

  always_comb begin
    word = rules_i[0];
    for (int j = 1; j < RULE_COUNT; j++) begin
      if (lane_i.rule == cic_pkg::RULE_IDX_W'(j)) word = rules_i[j];
    end
  end

  // Decode digit through the traversal, or encode quadrant from the bits.
  assign digit = lane_i.curve_position[2*LEVEL +: 2];

  always_comb begin
    if (lane_i.action == cic_pkg::ACT_DECODE) begin
      case (digit)
        2'd0:    quad = word[1:0];
        2'd1:    quad = word[3:2];
        2'd2:    quad = word[5:4];
        2'd3:    quad = word[7:6];
        default: quad = word[1:0];
      endcase
    end else begin
      quad = {lane_i.x_cell[LEVEL], ~lane_i.y_cell[LEVEL]};
    end
  end

  // Position table is the inverse of the traversal; later entries win.
  always_comb begin
    enc_pos = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (word[2*d +: 2] == quad) enc_pos = 2'(d);
    end
  end

  always_comb begin
    case (quad)
      2'd0:    next_raw = word[10:8];
      2'd1:    next_raw = word[13:11];
      2'd2:    next_raw = word[16:14];
      2'd3:    next_raw = word[19:17];
      default: next_raw = word[10:8];
    endcase
    next_rule = (next_raw >= 3'(RULE_COUNT)) ? '0 : next_raw;
  end

  always_comb begin
    lane_nxt = lane_i;
    if (active) begin
      lane_nxt.rule = next_rule;
      if (lane_i.action == cic_pkg::ACT_DECODE) begin
        lane_nxt.x_acc = {lane_i.x_acc[cic_pkg::COORD_W-2:0], quad[1]};
        lane_nxt.y_acc = {lane_i.y_acc[cic_pkg::COORD_W-2:0], ~quad[0]};
      end else begin
        lane_nxt.index_acc = {lane_i.index_acc[cic_pkg::INDEX_W-3:0], enc_pos};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
    lane_r.action         <= lane_nxt.action;
    lane_r.x_cell         <= lane_nxt.x_cell;
    lane_r.y_cell         <= lane_nxt.y_cell;
    lane_r.curve_position <= lane_nxt.curve_position;
    lane_r.rule           <= lane_nxt.rule;
    lane_r.index_acc      <= lane_nxt.index_acc;
    lane_r.x_acc          <= lane_nxt.x_acc;
    lane_r.y_acc          <= lane_nxt.y_acc;
  end

  assign lane_o = lane_r;

endmodule

// ===== hw/rtl/curve_index_encode_decode.sv =====
// Top level of the rule-table space-filling-curve index encoder and decoder.
//
// Each item either encodes a grid cell (in_x_cell, in_y_cell) into its curve
// index or decodes a curve index (in_curve_position) back into a cell, as chosen
// by in_action. An item is accepted on any clock edge where start is high and
// busy is low; busy is high only while reset is held, so a new item can enter
// on every cycle. The walk runs through a row of MAX_ORDER cells, one per bit
// level, and each cell registers its result, so every item comes out of the
// last cell's register, in acceptance order. The result is shown for a single
// cycle with out_strobe high; the receiver cannot stall the block and must
// take it then. Levels at or above the programmed curve_order pass through
// their cells unchanged. The configuration registers (curve_order and the
// seven rule words) are written through cfg_we, cfg_index and cfg_data and
// must only be changed while no item is in flight.
module curve_index_encode_decode #(
  parameter int unsigned MAX_ORDER  = cic_pkg::MAX_ORDER_DEF,
  parameter int unsigned RULE_COUNT = cic_pkg::RULE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_action,
  input  logic [cic_pkg::COORD_W-1:0]     in_x_cell,
  input  logic [cic_pkg::COORD_W-1:0]     in_y_cell,
  input  logic [cic_pkg::INDEX_W-1:0]     in_curve_position,
  output logic                            out_strobe,
  output logic [cic_pkg::INDEX_W-1:0]     out_index_out,
  output logic [cic_pkg::COORD_W-1:0]     out_x_out,
  output logic [cic_pkg::COORD_W-1:0]     out_y_out,
  input  logic                            cfg_we,
  input  logic [cic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cic_pkg::RULE_W-1:0]      cfg_data
);

  logic [cic_pkg::ORDER_W-1:0] order_r;
  logic [cic_pkg::ORDER_W-1:0] order_act;
  logic [cic_pkg::RULE_W-1:0]  rules_r [RULE_COUNT];
  logic                        in_fire;
  cic_pkg::lane_t              lanes [MAX_ORDER+1];

  // Configuration registers. Rule words beyond the table size are never
  // selected, so writes to them are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= cic_pkg::ORDER_RESET;
      for (int j = 0; j < RULE_COUNT; j++) rules_r[j] <= cic_pkg::RULE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cic_pkg::CFG_ORDER) begin
        order_r <= cfg_data[cic_pkg::ORDER_W-1:0];
      end
      for (int j = 0; j < RULE_COUNT; j++) begin
        if (cfg_index == cic_pkg::CFG_RULE_BASE + cic_pkg::CFG_IDX_W'(j)) begin
          rules_r[j] <= cfg_data;
        end
      end
    end
  end

  // An order above the number of cells walks every cell.
  assign order_act = (order_r > cic_pkg::ORDER_W'(MAX_ORDER)) ?
                     cic_pkg::ORDER_W'(MAX_ORDER) : order_r;

  assign busy    = ~rst_n;
  assign in_fire = start & ~busy;

  // The walk starts at rule 0 with empty accumulators.
  always_comb begin
    lanes[0].valid          = in_fire;
    lanes[0].action         = in_action;
    lanes[0].x_cell         = in_x_cell;
    lanes[0].y_cell         = in_y_cell;
    lanes[0].curve_position = in_curve_position;
    lanes[0].rule           = '0;
    lanes[0].index_acc      = '0;
    lanes[0].x_acc          = '0;
    lanes[0].y_acc          = '0;
  end

  // Cell k handles the bit level MAX_ORDER-1-k, most significant level first.
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    cic_cell #(
      .LEVEL      (MAX_ORDER - 1 - k),
      .RULE_COUNT (RULE_COUNT)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .order_i (order_act),
      .rules_i (rules_r),
      .lane_i  (lanes[k]),
      .lane_o  (lanes[k+1])
    );
  end

  // Encode leaves the coordinate accumulators at zero and decode leaves the
  // index accumulator at zero, so the fields go out directly.
  assign out_strobe    = lanes[MAX_ORDER].valid;
  assign out_index_out = lanes[MAX_ORDER].index_acc;
  assign out_x_out     = lanes[MAX_ORDER].x_acc;
  assign out_y_out     = lanes[MAX_ORDER].y_acc;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_fire, MAX_ORDER))
    else $error("result strobe without an item accepted MAX_ORDER cycles earlier");

  a_one_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_index_out == '0) || ((out_x_out == '0) && (out_y_out == '0)))
    else $error("result carries both an index and a cell");

  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");
`endif

endmodule

// ===== sim/curve_index_encode_decode_test.sv =====
// Self-checking testbench for the rule-table curve index encoder and decoder.
module curve_index_encode_decode_test;
  import cic_pkg::*;

  // One lookup as offered on the command port.
  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x_cell;
    logic [COORD_W-1:0] y_cell;
    logic [INDEX_W-1:0] curve_position;
  } lookup_t;

  // The answer the block owes for one lookup.
  typedef struct packed {
    logic               for_decode;
    logic [INDEX_W-1:0] index_out;
    logic [COORD_W-1:0] x_out;
    logic [COORD_W-1:0] y_out;
  } answer_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_LOOKUPS = 85;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = ACT_ENCODE;
  logic [COORD_W-1:0] in_x_cell = '0;
  logic [COORD_W-1:0] in_y_cell = '0;
  logic [INDEX_W-1:0] in_curve_position = '0;
  logic out_strobe;
  logic [INDEX_W-1:0] out_index_out;
  logic [COORD_W-1:0] out_x_out;
  logic [COORD_W-1:0] out_y_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RULE_W-1:0] cfg_data = '0;

  // Lookups waiting to be offered, and answers waiting for the block.
  lookup_t lookup_queue[$];
  answer_t answer_queue[$];
  lookup_t offered;

  // Our own copy of the programmed curve, kept in step with every write.
  logic [ORDER_W-1:0] order_reg = ORDER_RESET;
  logic [RULE_W-1:0] rule_word[RULE_COUNT_DEF] = '{default: RULE_RESET};
  // Rule words to be loaded by the next table load.
  logic [RULE_W-1:0] rule_plan[RULE_COUNT_DEF];

  int unsigned idle_pct = 28;
  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;
  int unsigned checked_encodes = 0;
  int unsigned checked_decodes = 0;
  int unsigned table_loads = 0;

  curve_index_encode_decode u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_x_cell         (in_x_cell),
    .in_y_cell         (in_y_cell),
    .in_curve_position (in_curve_position),
    .out_strobe        (out_strobe),
    .out_index_out     (out_index_out),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  // Walk the curve for one lookup with the current table. Levels run from the
  // top coordinate bit down, starting in rule 0. An encode turns the x bit and
  // the inverted y bit into a quadrant and looks up its digit; when the
  // traversal is not a permutation the last entry naming the quadrant wins,
  // and an unnamed quadrant gets digit 0. A decode maps each index digit
  // through the traversal back to a quadrant. Next-rule numbers past the end
  // of the table fall back to rule 0, and an order above the maximum is
  // clipped to it.
  function automatic answer_t curve_walk(lookup_t lk);
    answer_t ans;
    int unsigned levels;
    int unsigned lv;
    int unsigned sh;
    int d;
    logic [2:0] rule;
    logic [2:0] nxt;
    logic [1:0] quad;
    logic [1:0] digit;
    logic [RULE_W-1:0] word;
    ans = '0;
    ans.for_decode = lk.action;
    levels = (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_reg;
    rule = '0;
    for (lv = 0; lv < levels; lv++) begin
      sh = levels - lv - 1;
      word = rule_word[rule];
      if (lk.action == ACT_ENCODE) begin
        quad = {lk.x_cell[sh], ~lk.y_cell[sh]};
        digit = 2'd0;
        for (d = 0; d < 4; d++) begin
          if (word[2*d +: 2] == quad) digit = 2'(d);
        end
        ans.index_out = {ans.index_out[INDEX_W-3:0], digit};
      end else begin
        digit = lk.curve_position[2*sh +: 2];
        quad = word[2*digit +: 2];
        ans.x_out = {ans.x_out[COORD_W-2:0], quad[1]};
        ans.y_out = {ans.y_out[COORD_W-2:0], ~quad[0]};
      end
      nxt = word[8 + 3*quad +: 3];
      rule = (nxt >= RULE_COUNT_DEF) ? 3'd0 : nxt;
    end
    return ans;
  endfunction

  // A random rule word. Most are proper permutations with next rules inside
  // the table; some carry an out-of-range next rule, and some are raw noise
  // that usually breaks the permutation.
  function automatic logic [RULE_W-1:0] random_rule();
    logic [1:0] perm[4];
    logic [1:0] tmp;
    logic [RULE_W-1:0] word;
    int i;
    int j;
    if ($urandom_range(99, 0) < 15) return RULE_W'($urandom());
    for (i = 0; i < 4; i++) perm[i] = 2'(i);
    for (i = 3; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    word = '0;
    for (i = 0; i < 4; i++) begin
      word[2*i +: 2] = perm[i];
      word[8 + 3*i +: 3] = ($urandom_range(9, 0) == 0) ? 3'd7 : 3'($urandom_range(6, 0));
    end
    return word;
  endfunction

  task automatic add_lookup(input logic act, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [INDEX_W-1:0] pos);
    lookup_t lk;
    lk.action = act;
    lk.x_cell = x;
    lk.y_cell = y;
    lk.curve_position = pos;
    lookup_queue.push_back(lk);
  endtask

  // Program the order and all seven rule words from rule_plan, back to back
  // with the write enable held high. Junk goes into the unused upper bits of
  // the order write, which the block must ignore.
  task automatic load_table(input logic [ORDER_W-1:0] ord);
    int r;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_data <= {(RULE_W-ORDER_W)'($urandom()), ord};
    order_reg = ord;
    for (r = 0; r < RULE_COUNT_DEF; r++) begin
      @(posedge clk);
      cfg_index <= CFG_RULE_BASE + 3'(r);
      cfg_data <= rule_plan[r];
      rule_word[r] = rule_plan[r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    table_loads++;
  endtask

  // Wait until every lookup has been offered and answered, then let the
  // pipeline run dry before anything touches the registers. Sampling on the
  // falling edge keeps the check clear of the updates made at the rising one.
  task automatic wait_drained();
    while (lookup_queue.size() != 0 || start || answer_queue.size() != 0)
      @(negedge clk);
    repeat (MAX_ORDER_DEF + 4) @(posedge clk);
  endtask

  // Driver. A lookup is taken when start is high and busy is low; its answer
  // is predicted right then, with the table that is programmed. While busy
  // holds a lookup off, the port keeps it unchanged. Otherwise the next
  // lookup is offered unless the sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) answer_queue.push_back(curve_walk(offered));
      if (lookup_queue.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        offered = lookup_queue.pop_front();
        start <= 1'b1;
        in_action <= offered.action;
        in_x_cell <= offered.x_cell;
        in_y_cell <= offered.y_cell;
        in_curve_position <= offered.curve_position;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. Every strobe carries one answer, in the order lookups were taken;
  // each is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_strobe) begin
      if (answer_queue.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("Unexpected result: index %h x %h y %h", out_index_out, out_x_out,
                   out_y_out);
      end else begin
        want = answer_queue.pop_front();
        if (want.for_decode) checked_decodes++;
        else checked_encodes++;
        if (out_index_out !== want.index_out || out_x_out !== want.x_out ||
            out_y_out !== want.y_out) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Mismatch (%s): index %h/%h x %h/%h y %h/%h (expected/actual)",
                     want.for_decode ? "decode" : "encode", want.index_out, out_index_out,
                     want.x_out, out_x_out, want.y_out, out_y_out);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    int unsigned ord;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lookups with the table left at its reset value: identity
    // traversal, every next rule 0, order 8. Bits at level 8 and above are set in
    // several of them and must not matter.
    add_lookup(ACT_ENCODE, 16'h0000, 16'h0000, '0);
    add_lookup(ACT_ENCODE, 16'hFFFF, 16'hFFFF, '0);
    add_lookup(ACT_ENCODE, 16'h00FF, 16'h0000, 32'hFFFF_FFFF);
    add_lookup(ACT_ENCODE, 16'h5A00, 16'hA5FF, '0);
    add_lookup(ACT_DECODE, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    add_lookup(ACT_DECODE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    add_lookup(ACT_DECODE, 16'h0000, 16'h0000, 32'h0000_ABCD);
    add_lookup(ACT_DECODE, 16'h0000, 16'h0000, 32'hFFFF_1234);
    wait_drained();

    // Full order with a hand-built table: rule 0 is a reversed traversal
    // whose last quadrant points past the table, rule 1 names two quadrants
    // twice and leaves the other two unnamed, and rule 2 is a scrambled
    // permutation.
    rule_plan[0] = {3'd7, 3'd2, 3'd1, 3'd0, 2'd0, 2'd1, 2'd2, 2'd3};
    rule_plan[1] = {3'd0, 3'd6, 3'd2, 3'd1, 2'd1, 2'd1, 2'd3, 2'd3};
    rule_plan[2] = {3'd5, 3'd1, 3'd0, 3'd2, 2'd2, 2'd0, 2'd3, 2'd1};
    for (r = 3; r < RULE_COUNT_DEF; r++) rule_plan[r] = random_rule();
    load_table(ORDER_W'(MAX_ORDER_DEF));
    add_lookup(ACT_ENCODE, 16'hFFFF, 16'h0000, '0);
    add_lookup(ACT_ENCODE, 16'h0000, 16'hFFFF, '0);
    add_lookup(ACT_ENCODE, 16'hFFFF, 16'hFFFF, '0);
    add_lookup(ACT_ENCODE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    add_lookup(ACT_DECODE, '0, '0, 32'hFFFF_FFFF);
    add_lookup(ACT_DECODE, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    add_lookup(ACT_DECODE, '0, '0, 32'hAAAA_AAAA);
    add_lookup(ACT_DECODE, '0, '0, 32'h5555_5555);
    wait_drained();

    // Order zero walks no levels, so every field comes back zero.
    load_table(ORDER_W'(0));
    add_lookup(ACT_ENCODE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_lookup(ACT_DECODE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();

    // Orders above the maximum act as the maximum.
    load_table(ORDER_W'(31));
    add_lookup(ACT_ENCODE, 16'h1234, 16'hABCD, '0);
    add_lookup(ACT_DECODE, '0, '0, 32'h9E37_79B9);
    wait_drained();
    load_table(ORDER_W'(17));
    add_lookup(ACT_ENCODE, 16'hC3A5, 16'h0F0F, '0);
    add_lookup(ACT_DECODE, '0, '0, 32'h7F4A_7C15);
    wait_drained();

    // Random phases, each with a fresh table. The first ones pin the order
    // extremes and fill the table with all-ones and all-zeros words; the rest
    // use random orders and mostly well-formed rules. One phase runs with the
    // sender never idling.
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: ord = 1;
        1: ord = MAX_ORDER_DEF;
        2: ord = 31;
        default: ord = $urandom_range(MAX_ORDER_DEF, 1);
      endcase
      for (r = 0; r < RULE_COUNT_DEF; r++) begin
        if (ph == 3) rule_plan[r] = '1;
        else if (ph == 4) rule_plan[r] = '0;
        else rule_plan[r] = random_rule();
      end
      load_table(ORDER_W'(ord));
      idle_pct = (ph == 6) ? 0 : 28;
      for (n = 0; n < PHASE_LOOKUPS; n++)
        add_lookup(1'($urandom_range(1, 0)), COORD_W'($urandom()), COORD_W'($urandom()),
                   $urandom());
      wait_drained();
    end

    fault_count += answer_queue.size();
    $display("Checked %0d encodes and %0d decodes across %0d table loads,", checked_encodes,
             checked_decodes, table_loads);
    $display("covering orders 0, 1, 16 and above 16 and both broken and proper rules.");
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== curve_index_encode_decode.f =====
hw/rtl/cic_pkg.sv
hw/rtl/cic_cell.sv
hw/rtl/curve_index_encode_decode.sv
sim/curve_index_encode_decode_test.sv
